/* rtl/cea_pkg.sv */
package cea_pkg;

  localparam int ACT_W      = 2;
  localparam int KEY_W      = 5;
  localparam int LEN_W      = 16;
  localparam int STATUS_W   = 3;
  localparam int START_W    = 6;
  localparam int USED_W     = 7;
  localparam int EC_W       = 7;
  localparam int ES_W       = 11;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 11;
  localparam int QW         = 17;
  localparam int PW         = 18;
  localparam int DIV_CW     = 5;

  localparam logic [EC_W-1:0] EC_RESET = 7'd64;
  localparam logic [ES_W-1:0] ES_RESET = 11'd64;

  localparam logic [CFG_IDX_W-1:0] CFG_ENTRY_COUNT = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_ENTRY_SIZE  = 1'b1;

  typedef enum logic [ACT_W-1:0] {
    ACT_REGISTER = 2'd0,
    ACT_SET      = 2'd1,
    ACT_STORE    = 2'd2,
    ACT_NONE     = 2'd3
  } action_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_KEY_SAVED        = 3'd0,
    ST_VALUE_SET        = 3'd1,
    ST_KEY_MISSING      = 3'd2,
    ST_NO_SPACE         = 3'd3,
    ST_NEEDS_COMPACTION = 3'd4,
    ST_STORED           = 3'd5,
    ST_NOT_STORED       = 3'd6
  } status_t;

endpackage

/* rtl/contiguous_entry_allocator.sv */
// First-fit contiguous allocator: keys are registered, then given runs of storage
// entries sized ceil(value_length / entry_size), rewritten, shrunk or grown in place
// where possible, else moved by a first-fit search over the occupancy bitmap. One word
// is in work at a time; in_ready is high only while the sequencer is idle, and the
// next word is taken while a result still waits at the output register. Register and
// store words go straight to the delivery step, which loads the result word into the
// output register once that register is free. A set word runs the bit-serial ceiling
// divider on the new length, then again on the current length of a placed key, then
// decides, then walks the bitmap one entry per cycle in each pass: the first-fit scan
// (up to min(entry_count, NUM_ENTRIES) entries), the growth check, and each clear or
// mark pass (each up to NUM_ENTRIES entries), and then delivers the result. Configuration
// words are taken in any cycle. No clearing pass follows reset.
module contiguous_entry_allocator #(
  parameter int NUM_ENTRIES   = 64,
  parameter int NUM_KEYS      = 32,
  parameter int MAX_VALUE_LEN = 65535
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [cea_pkg::ACT_W-1:0]         in_action,
  input  logic [cea_pkg::KEY_W-1:0]         in_key_id,
  input  logic [cea_pkg::LEN_W-1:0]         in_value_length,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [cea_pkg::STATUS_W-1:0]      out_status,
  output logic [cea_pkg::START_W-1:0]       out_start_entry,
  output logic [cea_pkg::USED_W-1:0]        out_entries_used,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [cea_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [cea_pkg::CFG_DATA_W-1:0]    cfg_data
);

  import cea_pkg::*;

  localparam int EW = $clog2(NUM_ENTRIES);
  localparam int KW = $clog2(NUM_KEYS);
  localparam int RW = EW + LEN_W;

  typedef enum logic [8:0] {
    S_IDLE   = 9'b000000001,
    S_DIVN   = 9'b000000010,
    S_DIVC   = 9'b000000100,
    S_DECIDE = 9'b000001000,
    S_GROW   = 9'b000010000,
    S_CLEAR  = 9'b000100000,
    S_SCAN   = 9'b001000000,
    S_SET    = 9'b010000000,
    S_OUT    = 9'b100000000
  } state_t;

  state_t state_r, state_nxt;

  logic [EC_W-1:0]        ec_r;
  logic [ES_W-1:0]        es_r;
  logic [NUM_ENTRIES-1:0] occ_r, occ_nxt;
  logic [NUM_KEYS-1:0]    present_r, present_nxt;
  logic [NUM_KEYS-1:0]    placed_r, placed_nxt;

  logic [KW-1:0]    key_r, key_nxt;
  logic [LEN_W-1:0] len_r, len_nxt;
  logic [QW-1:0]    need_r, need_nxt;
  logic [QW-1:0]    cur_r, cur_nxt;
  logic [EW-1:0]    start_r, start_nxt;
  logic [PW-1:0]    pos_r, pos_nxt;
  logic [QW-1:0]    cnt_r, cnt_nxt;
  logic [QW-1:0]    run_r, run_nxt;
  logic [QW-1:0]    free_r, free_nxt;
  logic             reloc_r, reloc_nxt;
  status_t          res_status_r, res_status_nxt;
  logic [EW-1:0]    res_start_r, res_start_nxt;
  logic [QW-1:0]    res_used_r, res_used_nxt;

  logic                out_valid_r, out_valid_nxt;
  logic [STATUS_W-1:0] out_status_r, out_status_nxt;
  logic [START_W-1:0]  out_start_r, out_start_nxt;
  logic [USED_W-1:0]   out_used_r, out_used_nxt;

  logic [ES_W:0]     div_rem_r;
  logic [QW-1:0]     div_quo_r;
  logic [DIV_CW-1:0] div_cnt_r;
  logic              div_load;
  logic [LEN_W-1:0]  div_operand;
  logic [ES_W-1:0]   es_eff;
  logic [QW-1:0]     div_dividend;
  logic [ES_W+1:0]   div_shift;
  logic [ES_W+2:0]   div_diff;
  logic              div_done;

  logic          ram_we;
  logic          ram_re;
  logic [KW-1:0] ram_raddr;
  logic [RW-1:0] ram_wdata;
  logic [RW-1:0] ram_rdata;
  logic [EW-1:0]    rd_start;
  logic [LEN_W-1:0] rd_len;

  logic [PW-1:0] live;
  logic          in_range;
  logic          occ_bit;
  logic [KW-1:0] key_in;
  logic          key_ok;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_status       = out_status_r;
  assign out_start_entry  = out_start_r;
  assign out_entries_used = out_used_r;
  assign cfg_ready = 1'b1;

  assign live     = (32'(ec_r) < 32'(NUM_ENTRIES)) ? PW'(ec_r) : PW'(NUM_ENTRIES);
  assign in_range = (pos_r < PW'(NUM_ENTRIES));
  assign occ_bit  = occ_r[pos_r[EW-1:0]];
  assign key_in   = KW'(in_key_id);
  assign key_ok   = (32'(in_key_id) < 32'(NUM_KEYS));
  assign rd_start = ram_rdata[RW-1:LEN_W];
  assign rd_len   = ram_rdata[LEN_W-1:0];

  // shared ceiling divider, one quotient bit per cycle
  assign es_eff       = (es_r == '0) ? ES_W'(1) : es_r;
  assign div_dividend = QW'(div_operand) + QW'(es_eff) - QW'(1);
  assign div_shift    = {div_rem_r, div_quo_r[QW-1]};
  assign div_diff     = {1'b0, div_shift} - (ES_W+3)'(es_eff);
  assign div_done     = (div_cnt_r == '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      div_cnt_r <= '0;
    end else if (div_load) begin
      div_cnt_r <= DIV_CW'(QW);
    end else if (!div_done) begin
      div_cnt_r <= div_cnt_r - DIV_CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (div_load) begin
      div_rem_r <= '0;
      div_quo_r <= div_dividend;
    end else if (!div_done) begin
      if (!div_diff[ES_W+2]) begin
        div_rem_r <= div_diff[ES_W:0];
        div_quo_r <= {div_quo_r[QW-2:0], 1'b1};
      end else begin
        div_rem_r <= div_shift[ES_W:0];
        div_quo_r <= {div_quo_r[QW-2:0], 1'b0};
      end
    end
  end

  cea_ram #(
    .WIDTH (RW),
    .DEPTH (NUM_KEYS)
  ) u_key_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (key_r),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign ram_wdata = {start_r, len_r};
  assign ram_raddr = key_in;

  always_comb begin
    state_nxt      = state_r;
    occ_nxt        = occ_r;
    present_nxt    = present_r;
    placed_nxt     = placed_r;
    key_nxt        = key_r;
    len_nxt        = len_r;
    need_nxt       = need_r;
    cur_nxt        = cur_r;
    start_nxt      = start_r;
    pos_nxt        = pos_r;
    cnt_nxt        = cnt_r;
    run_nxt        = run_r;
    free_nxt       = free_r;
    reloc_nxt      = reloc_r;
    res_status_nxt = res_status_r;
    res_start_nxt  = res_start_r;
    res_used_nxt   = res_used_r;
    div_load       = 1'b0;
    div_operand    = len_r;
    ram_we         = 1'b0;
    ram_re         = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (in_valid && (action_t'(in_action) != ACT_NONE)) begin
          key_nxt       = key_in;
          len_nxt       = in_value_length;
          res_start_nxt = '0;
          res_used_nxt  = '0;
          state_nxt     = S_OUT;
          if (!key_ok) begin
            res_status_nxt = ST_KEY_MISSING;
          end else begin
            unique case (action_t'(in_action))
              ACT_REGISTER: begin
                present_nxt[key_in] = 1'b1;
                placed_nxt[key_in]  = 1'b0;
                res_status_nxt      = ST_KEY_SAVED;
              end
              ACT_SET: begin
                if (!present_r[key_in]) begin
                  res_status_nxt = ST_KEY_MISSING;
                end else if (32'(in_value_length) > 32'(MAX_VALUE_LEN)) begin
                  res_status_nxt = ST_NO_SPACE;
                end else begin
                  div_load    = 1'b1;
                  div_operand = in_value_length;
                  ram_re      = 1'b1;
                  state_nxt   = S_DIVN;
                end
              end
              ACT_STORE: begin
                res_status_nxt = (present_r[key_in] && placed_r[key_in]) ?
                                 ST_STORED : ST_NOT_STORED;
              end
              default: begin
                res_status_nxt = ST_KEY_MISSING;
              end
            endcase
          end
        end
      end

      S_DIVN: begin
        if (div_done) begin
          need_nxt = div_quo_r;
          if (placed_r[key_r]) begin
            start_nxt   = rd_start;
            div_load    = 1'b1;
            div_operand = rd_len;
            state_nxt   = S_DIVC;
          end else begin
            pos_nxt   = '0;
            run_nxt   = '0;
            free_nxt  = '0;
            reloc_nxt = 1'b0;
            state_nxt = S_SCAN;
          end
        end
      end

      S_DIVC: begin
        if (div_done) begin
          cur_nxt   = div_quo_r;
          state_nxt = S_DECIDE;
        end
      end

      S_DECIDE: begin
        priority if (need_r == cur_r) begin
          pos_nxt   = PW'(start_r);
          cnt_nxt   = need_r;
          state_nxt = S_SET;
        end else if (need_r < cur_r) begin
          pos_nxt   = PW'(start_r);
          cnt_nxt   = cur_r;
          reloc_nxt = 1'b0;
          state_nxt = S_CLEAR;
        end else begin
          pos_nxt   = PW'(start_r) + PW'(cur_r);
          cnt_nxt   = need_r - cur_r;
          state_nxt = S_GROW;
        end
      end

      S_GROW: begin
        priority if (cnt_r == '0) begin
          pos_nxt   = PW'(start_r);
          cnt_nxt   = need_r;
          state_nxt = S_SET;
        end else if ((pos_r >= live) || occ_bit) begin
          pos_nxt   = PW'(start_r);
          cnt_nxt   = cur_r;
          reloc_nxt = 1'b1;
          state_nxt = S_CLEAR;
        end else begin
          pos_nxt = pos_r + PW'(1);
          cnt_nxt = cnt_r - QW'(1);
        end
      end

      S_CLEAR: begin
        if ((cnt_r == '0) || !in_range) begin
          if (reloc_r) begin
            pos_nxt   = '0;
            run_nxt   = '0;
            free_nxt  = '0;
            state_nxt = S_SCAN;
          end else begin
            pos_nxt   = PW'(start_r);
            cnt_nxt   = need_r;
            state_nxt = S_SET;
          end
        end else begin
          occ_nxt[pos_r[EW-1:0]] = 1'b0;
          pos_nxt = pos_r + PW'(1);
          cnt_nxt = cnt_r - QW'(1);
        end
      end

      S_SCAN: begin
        priority if (run_r == need_r) begin
          start_nxt = EW'(pos_r - PW'(need_r));
          pos_nxt   = pos_r - PW'(need_r);
          cnt_nxt   = need_r;
          state_nxt = S_SET;
        end else if (pos_r >= live) begin
          if (reloc_r) begin
            placed_nxt[key_r] = 1'b0;
            res_status_nxt    = ST_NEEDS_COMPACTION;
          end else if (free_r < need_r) begin
            res_status_nxt = ST_NO_SPACE;
          end else begin
            res_status_nxt = ST_NEEDS_COMPACTION;
          end
          state_nxt = S_OUT;
        end else begin
          if (!occ_bit) begin
            run_nxt  = run_r + QW'(1);
            free_nxt = free_r + QW'(1);
          end else begin
            run_nxt = '0;
          end
          pos_nxt = pos_r + PW'(1);
        end
      end

      S_SET: begin
        if ((cnt_r == '0) || !in_range) begin
          ram_we            = 1'b1;
          placed_nxt[key_r] = 1'b1;
          res_status_nxt    = ST_VALUE_SET;
          res_start_nxt     = start_r;
          res_used_nxt      = need_r;
          state_nxt         = S_OUT;
        end else begin
          occ_nxt[pos_r[EW-1:0]] = 1'b1;
          pos_nxt = pos_r + PW'(1);
          cnt_nxt = cnt_r - QW'(1);
        end
      end

      S_OUT: begin
        if (!out_valid_r || out_ready) begin
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt  = out_valid_r && !out_ready;
    out_status_nxt = out_status_r;
    out_start_nxt  = out_start_r;
    out_used_nxt   = out_used_r;
    if ((state_r == S_OUT) && (!out_valid_r || out_ready)) begin
      out_valid_nxt  = 1'b1;
      out_status_nxt = res_status_r;
      out_start_nxt  = START_W'(res_start_r);
      out_used_nxt   = USED_W'(res_used_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      ec_r        <= EC_RESET;
      es_r        <= ES_RESET;
      occ_r       <= '0;
      present_r   <= '0;
      placed_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      occ_r       <= occ_nxt;
      present_r   <= present_nxt;
      placed_r    <= placed_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid) begin
        unique case (cfg_index)
          CFG_ENTRY_COUNT: ec_r <= cfg_data[EC_W-1:0];
          CFG_ENTRY_SIZE:  es_r <= cfg_data[ES_W-1:0];
          default:         ec_r <= ec_r;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    key_r        <= key_nxt;
    len_r        <= len_nxt;
    need_r       <= need_nxt;
    cur_r        <= cur_nxt;
    start_r      <= start_nxt;
    pos_r        <= pos_nxt;
    cnt_r        <= cnt_nxt;
    run_r        <= run_nxt;
    free_r       <= free_nxt;
    reloc_r      <= reloc_nxt;
    res_status_r <= res_status_nxt;
    res_start_r  <= res_start_nxt;
    res_used_r   <= res_used_nxt;
    out_status_r <= out_status_nxt;
    out_start_r  <= out_start_nxt;
    out_used_r   <= out_used_nxt;
  end

  a_placed_needs_present: assert property (@(posedge clk) disable iff (!rst_n)
    (placed_r & ~present_r) == '0)
    else $error("placed key is not present");

  a_scan_in_bounds: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN) |-> (pos_r <= live))
    else $error("first-fit scan ran past the live entries");

  a_result_from_out: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(state_r) == S_OUT))
    else $error("result word loaded outside the delivery step");

endmodule

/* rtl/cea_ram.sv */
module cea_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
